FILE: hw/rtl/bpesh_pkg.sv
package bpesh_pkg;

  // histogram geometry
  localparam int COUNT_BITS = 16;
  localparam int BIN_BITS   = 8;
  localparam int OUT_COUNT_BITS = 16;

  localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = {COUNT_BITS{1'b1}};
  localparam logic [BIN_BITS-1:0]   LAST_BIN    = {BIN_BITS{1'b1}};

  // result queue geometry
  localparam int OUTQ_PTR_BITS = 2;
  localparam int OUTQ_DEPTH    = 1 << OUTQ_PTR_BITS;

  // item opcodes
  typedef enum logic [1:0] {
    OP_SPLIT      = 2'd0,
    OP_READ       = 2'd1,
    OP_READ_CLEAR = 2'd2
  } opcode_t;

  // one result item
  typedef struct packed {
    logic [7:0]                exponent_low;
    logic [7:0]                exponent_high;
    logic [7:0]                sign_mant_byte_a;
    logic [7:0]                sign_mant_byte_b;
    logic [OUT_COUNT_BITS-1:0] bin_count;
  } result_t;

endpackage

FILE: hw/rtl/bpesh_ram.sv
module bpesh_ram #(
  parameter int WIDTH     = 16,
  parameter int ADDR_BITS = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  localparam int DEPTH = 1 << ADDR_BITS;

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/bpesh_outq.sv
module bpesh_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  bpesh_pkg::result_t              push_item,
  output logic [bpesh_pkg::OUTQ_PTR_BITS:0] count,
  output logic                            head_valid,
  input  logic                            head_stall,
  output bpesh_pkg::result_t              head_item
);

  bpesh_pkg::result_t entries [bpesh_pkg::OUTQ_DEPTH];

  logic [bpesh_pkg::OUTQ_PTR_BITS-1:0] wr_ptr;
  logic [bpesh_pkg::OUTQ_PTR_BITS-1:0] rd_ptr;
  logic                                pop;

  assign head_valid = (count != '0);
  assign pop        = head_valid && !head_stall;
  assign head_item  = entries[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

FILE: hw/rtl/bf16_pair_exponent_split_histogram.sv
// Splits words holding two bfloat16 values into exponent and sign-plus-mantissa
// bytes and keeps a saturating 256-bin histogram of the exponents. One item is
// taken per clock cycle while in_stall is low, back to back; its result is built
// from registered memory reads and then queued. The histogram lives in two
// 256-entry memories with registered reads, one counting low-half exponents and
// one counting high-half exponents; each takes one read and one write per cycle,
// a read of a bin returns the saturated sum of both, and a write from the
// previous item is forwarded to the next one. Results wait in a four-entry
// queue, so in_stall rises when that queue and the item in flight fill it. After
// reset a clearing pass zeroes every bin, during which in_stall is held high.
module bf16_pair_exponent_split_histogram (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  opcode,
  input  logic [31:0] data_word,
  input  logic [7:0]  bin_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  exponent_low,
  output logic [7:0]  exponent_high,
  output logic [7:0]  sign_mant_byte_a,
  output logic [7:0]  sign_mant_byte_b,
  output logic [15:0] bin_count
);

  localparam int CB = bpesh_pkg::COUNT_BITS;
  localparam int BB = bpesh_pkg::BIN_BITS;
  localparam int OB = bpesh_pkg::OUT_COUNT_BITS;
  localparam int PB = bpesh_pkg::OUTQ_PTR_BITS;

  logic          accept;
  logic [31:0]   rot;
  logic          in_split;
  logic [BB-1:0] raddr_lo;
  logic [BB-1:0] raddr_hi;

  // clearing pass
  logic          clr_active;
  logic [BB-1:0] clr_addr;

  // stage 1: read data back from memory
  logic          s1_valid;
  logic [1:0]    s1_op;
  logic [BB-1:0] s1_addr_lo;
  logic [BB-1:0] s1_addr_hi;
  logic [7:0]    s1_byte_a;
  logic [7:0]    s1_byte_b;

  // last item write per bank, for forwarding
  logic          wb_lo_valid;
  logic [BB-1:0] wb_lo_addr;
  logic [CB-1:0] wb_lo_data;
  logic          wb_hi_valid;
  logic [BB-1:0] wb_hi_addr;
  logic [CB-1:0] wb_hi_data;

  logic [CB-1:0] rdata_lo;
  logic [CB-1:0] rdata_hi;
  logic [CB-1:0] cur_lo;
  logic [CB-1:0] cur_hi;
  logic [CB-1:0] inc_lo;
  logic [CB-1:0] inc_hi;
  logic          item_we;
  logic [CB-1:0] item_wdata_lo;
  logic [CB-1:0] item_wdata_hi;
  logic          we;
  logic [BB-1:0] waddr_lo;
  logic [BB-1:0] waddr_hi;
  logic [CB-1:0] wdata_lo;
  logic [CB-1:0] wdata_hi;
  logic [CB:0]   sum;
  logic [CB-1:0] sum_sat;
  logic [CB+OB-1:0] sum_ext;

  bpesh_pkg::result_t s1_result;
  bpesh_pkg::result_t head_item;
  logic [PB:0]        q_count;
  logic [PB:0]        occupancy;

  // input side
  assign occupancy = q_count + (PB+1)'(s1_valid);
  assign in_stall  = clr_active || (occupancy >= (PB+1)'(bpesh_pkg::OUTQ_DEPTH));
  assign accept    = in_valid && !in_stall;

  // rotate left by one and pick the bins to read
  assign rot      = {data_word[30:0], data_word[31]};
  assign in_split = (opcode == bpesh_pkg::OP_SPLIT);
  assign raddr_lo = in_split ? rot[15:8]  : bin_index;
  assign raddr_hi = in_split ? rot[31:24] : bin_index;

  // clearing pass after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_addr   <= '0;
    end else if (clr_active) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == bpesh_pkg::LAST_BIN) begin
        clr_active <= 1'b0;
      end
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op      <= opcode;
      s1_addr_lo <= raddr_lo;
      s1_addr_hi <= raddr_hi;
      s1_byte_a  <= rot[7:0];
      s1_byte_b  <= rot[23:16];
    end
  end

  // histogram banks
  bpesh_ram #(.WIDTH(CB), .ADDR_BITS(BB)) u_ram_lo (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_lo),
    .wdata (wdata_lo),
    .raddr (raddr_lo),
    .rdata (rdata_lo)
  );

  bpesh_ram #(.WIDTH(CB), .ADDR_BITS(BB)) u_ram_hi (
    .clk   (clk),
    .we    (we),
    .waddr (waddr_hi),
    .wdata (wdata_hi),
    .raddr (raddr_hi),
    .rdata (rdata_hi)
  );

  // forward, modify and select the write
  always_comb begin
    cur_lo = (wb_lo_valid && (wb_lo_addr == s1_addr_lo)) ? wb_lo_data : rdata_lo;
    cur_hi = (wb_hi_valid && (wb_hi_addr == s1_addr_hi)) ? wb_hi_data : rdata_hi;
    inc_lo = (cur_lo == bpesh_pkg::COUNT_LIMIT) ? cur_lo : cur_lo + 1'b1;
    inc_hi = (cur_hi == bpesh_pkg::COUNT_LIMIT) ? cur_hi : cur_hi + 1'b1;

    item_we = s1_valid && ((s1_op == bpesh_pkg::OP_SPLIT) ||
                           (s1_op == bpesh_pkg::OP_READ_CLEAR));
    item_wdata_lo = (s1_op == bpesh_pkg::OP_SPLIT) ? inc_lo : '0;
    item_wdata_hi = (s1_op == bpesh_pkg::OP_SPLIT) ? inc_hi : '0;

    we       = clr_active || item_we;
    waddr_lo = clr_active ? clr_addr : s1_addr_lo;
    waddr_hi = clr_active ? clr_addr : s1_addr_hi;
    wdata_lo = clr_active ? '0 : item_wdata_lo;
    wdata_hi = clr_active ? '0 : item_wdata_hi;
  end

  // forwarding registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_lo_valid <= 1'b0;
      wb_hi_valid <= 1'b0;
    end else begin
      wb_lo_valid <= item_we;
      wb_hi_valid <= item_we;
    end
  end

  always_ff @(posedge clk) begin
    if (item_we) begin
      wb_lo_addr <= s1_addr_lo;
      wb_lo_data <= item_wdata_lo;
      wb_hi_addr <= s1_addr_hi;
      wb_hi_data <= item_wdata_hi;
    end
  end

  // bin total and result item
  always_comb begin
    sum       = {1'b0, cur_lo} + {1'b0, cur_hi};
    sum_sat   = sum[CB] ? bpesh_pkg::COUNT_LIMIT : sum[CB-1:0];
    sum_ext   = (CB+OB)'(sum_sat);
    s1_result = '0;
    case (s1_op)
      bpesh_pkg::OP_SPLIT: begin
        s1_result.exponent_low     = s1_addr_lo;
        s1_result.exponent_high    = s1_addr_hi;
        s1_result.sign_mant_byte_a = s1_byte_a;
        s1_result.sign_mant_byte_b = s1_byte_b;
      end
      bpesh_pkg::OP_READ, bpesh_pkg::OP_READ_CLEAR: begin
        s1_result.bin_count = sum_ext[OB-1:0];
      end
      default: begin
        s1_result = '0;
      end
    endcase
  end

  // result queue
  bpesh_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (s1_valid),
    .push_item  (s1_result),
    .count      (q_count),
    .head_valid (out_valid),
    .head_stall (out_stall),
    .head_item  (head_item)
  );

  assign exponent_low     = head_item.exponent_low;
  assign exponent_high    = head_item.exponent_high;
  assign sign_mant_byte_a = head_item.sign_mant_byte_a;
  assign sign_mant_byte_b = head_item.sign_mant_byte_b;
  assign bin_count        = head_item.bin_count;

endmodule

FILE: sim/bf16_pair_exponent_split_histogram_test.sv
`timescale 1ns / 100ps

module bf16_pair_exponent_split_histogram_test;

  // opcode the block leaves unused: no state change, all-zero result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int LIMIT_NS = 20_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam bpesh_pkg::result_t ALL_ZERO = '0;

  typedef struct {
    logic [1:0]         op;
    logic [31:0]        word;
    logic [7:0]         bin;
    logic               typed;
    bpesh_pkg::result_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  opcode;
  logic [31:0] data_word;
  logic [7:0]  bin_index;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  exponent_low;
  logic [7:0]  exponent_high;
  logic [7:0]  sign_mant_byte_a;
  logic [7:0]  sign_mant_byte_b;
  logic [15:0] bin_count;

  // predicted histogram and results still owed by the block
  logic [bpesh_pkg::COUNT_BITS-1:0] exp_counts [256];
  bpesh_pkg::result_t               pending_results [$];
  stim_row_t                        directed_rows [$];

  int errors = 0;
  bit steady_flow = 1'b0;
  int hold_request = 0;

  bf16_pair_exponent_split_histogram uut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .opcode           (opcode),
    .data_word        (data_word),
    .bin_index        (bin_index),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .exponent_low     (exponent_low),
    .exponent_high    (exponent_high),
    .sign_mant_byte_a (sign_mant_byte_a),
    .sign_mant_byte_b (sign_mant_byte_b),
    .bin_count        (bin_count)
  );

  // 100 MHz clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // saturating bin update
  function automatic void count_exponent(logic [7:0] bin, int amount);
    logic [bpesh_pkg::COUNT_BITS:0] sum;
    sum = {1'b0, exp_counts[bin]} + (bpesh_pkg::COUNT_BITS+1)'(amount);
    exp_counts[bin] = (sum > bpesh_pkg::COUNT_LIMIT) ? bpesh_pkg::COUNT_LIMIT
                                                     : sum[bpesh_pkg::COUNT_BITS-1:0];
  endfunction

  // expected result of one item, histogram updated on the way
  function automatic bpesh_pkg::result_t split_and_count(logic [1:0] op, logic [31:0] word,
                                                         logic [7:0] bin);
    bpesh_pkg::result_t r;
    logic [31:0]        rot;
    r = '0;
    case (op)
      bpesh_pkg::OP_SPLIT: begin
        rot = {word[30:0], word[31]};
        r.exponent_low     = rot[15:8];
        r.exponent_high    = rot[31:24];
        r.sign_mant_byte_a = rot[7:0];
        r.sign_mant_byte_b = rot[23:16];
        if (rot[15:8] == rot[31:24]) begin
          count_exponent(rot[15:8], 2);
        end else begin
          count_exponent(rot[15:8], 1);
          count_exponent(rot[31:24], 1);
        end
      end
      bpesh_pkg::OP_READ, bpesh_pkg::OP_READ_CLEAR: begin
        r.bin_count = bpesh_pkg::OUT_COUNT_BITS'(exp_counts[bin]);
        if (op == bpesh_pkg::OP_READ_CLEAR) exp_counts[bin] = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // exponent biased toward the edges and the middle so bins collide
  function automatic logic [7:0] pick_exponent();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h7F;
      3: return 8'h80;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // random word carrying the given low and high exponents
  function automatic logic [31:0] word_with_exponents(logic [7:0] lo, logic [7:0] hi);
    logic [31:0] w;
    w = $urandom();
    w[14:7]  = lo;
    w[30:23] = hi;
    return w;
  endfunction

  // offer one item, wait for it to be taken, record what it should give
  task automatic drive_item(input logic [1:0] op, input logic [31:0] word,
                            input logic [7:0] bin, input logic typed,
                            input bpesh_pkg::result_t want);
    bpesh_pkg::result_t predicted;
    int                 gap;
    in_valid  <= 1'b1;
    opcode    <= op;
    data_word <= word;
    bin_index <= bin;
    do @(posedge clk); while (in_stall !== 1'b0);
    predicted = split_and_count(op, word, bin);
    pending_results.push_back(typed ? want : predicted);
    gap = steady_flow ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering until every owed result is back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result side: check each taken result, stall at random or on request
  initial begin : result_side
    int                 stall_left;
    int                 n;
    bpesh_pkg::result_t want;
    stall_left = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (pending_results.size() == 0) begin
          $error("result item arrived with no item pending");
          errors++;
        end else begin
          want = pending_results.pop_front();
          if (exponent_low !== want.exponent_low) begin
            $error("exponent_low expected %0h actual %0h", want.exponent_low, exponent_low);
            errors++;
          end
          if (exponent_high !== want.exponent_high) begin
            $error("exponent_high expected %0h actual %0h", want.exponent_high,
                   exponent_high);
            errors++;
          end
          if (sign_mant_byte_a !== want.sign_mant_byte_a) begin
            $error("sign_mant_byte_a expected %0h actual %0h", want.sign_mant_byte_a,
                   sign_mant_byte_a);
            errors++;
          end
          if (sign_mant_byte_b !== want.sign_mant_byte_b) begin
            $error("sign_mant_byte_b expected %0h actual %0h", want.sign_mant_byte_b,
                   sign_mant_byte_b);
            errors++;
          end
          if (bin_count !== want.bin_count) begin
            $error("bin_count expected %0h actual %0h", want.bin_count, bin_count);
            errors++;
          end
        end
      end
      if (hold_request != 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (steady_flow) begin
        out_stall <= 1'b0;
      end else begin
        n = pick_gap();
        out_stall <= (n != 0);
        stall_left = (n > 0) ? n - 1 : 0;
      end
    end
  end

  // item side: reset, directed table, pressure, random
  initial begin : item_side
    logic [1:0]  op;
    logic [31:0] word;
    logic [7:0]  bin;
    logic [7:0]  e_lo;
    int          r;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    opcode    <= bpesh_pkg::OP_SPLIT;
    data_word <= '0;
    bin_index <= '0;
    foreach (exp_counts[i]) exp_counts[i] = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // edges of every field, every opcode, reads after reset
    directed_rows = '{
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'h00, 1'b1, ALL_ZERO},
      '{bpesh_pkg::OP_READ, 32'hFFFF_FFFF, 8'hFF, 1'b1, ALL_ZERO},
      '{OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'h0000_0000, 8'h00, 1'b1, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'hFFFF_FFFF, 8'h00, 1'b1,
        {8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'd0}},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'h00, 1'b1, {32'h0, 16'd2}},
      '{bpesh_pkg::OP_READ_CLEAR, 32'h0000_0000, 8'hFF, 1'b1, {32'h0, 16'd2}},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'hFF, 1'b1, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'h8000_0000, 8'h00, 1'b1,
        {8'h00, 8'h00, 8'h01, 8'h00, 16'd0}},
      '{bpesh_pkg::OP_SPLIT, 32'h0000_8000, 8'h00, 1'b1,
        {8'h00, 8'h00, 8'h00, 8'h01, 16'd0}},
      '{bpesh_pkg::OP_SPLIT, 32'h7F80_0000, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'h0000_7F80, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'h3F80_3F80, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'hBF80_4000, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'h007F_007F, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_SPLIT, 32'h5555_AAAA, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'h7F, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ_CLEAR, 32'h0000_0000, 8'h7F, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'h7F, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ_CLEAR, 32'h0000_0000, 8'h00, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'hFF, 1'b0, ALL_ZERO},
      '{bpesh_pkg::OP_READ, 32'h0000_0000, 8'h80, 1'b0, ALL_ZERO},
      '{OP_UNUSED, 32'h1234_5678, 8'h7F, 1'b1, ALL_ZERO}
    };
    foreach (directed_rows[i])
      drive_item(directed_rows[i].op, directed_rows[i].word, directed_rows[i].bin,
                 directed_rows[i].typed, directed_rows[i].want);
    wait_drained();

    // long result hold while items keep coming, so the input backs up
    steady_flow = 1'b1;
    hold_request = HOLD_CYCLES;
    for (int k = 0; k < 40; k++)
      drive_item((k % 4 == 3) ? bpesh_pkg::OP_READ : bpesh_pkg::OP_SPLIT,
                 word_with_exponents(pick_exponent(), pick_exponent()),
                 pick_exponent(), 1'b0, ALL_ZERO);
    wait_drained();
    steady_flow = 1'b0;

    // random mix in blocks, every third block without idling
    for (int blk = 0; blk < 9; blk++) begin
      steady_flow = (blk % 3 == 2);
      if (blk == 4) wait_drained();
      for (int k = 0; k < 100; k++) begin
        r = $urandom_range(0, 99);
        if (r < 70) op = bpesh_pkg::OP_SPLIT;
        else if (r < 82) op = bpesh_pkg::OP_READ;
        else if (r < 94) op = bpesh_pkg::OP_READ_CLEAR;
        else op = OP_UNUSED;
        if ($urandom_range(0, 1) == 1) begin
          word = $urandom();
        end else begin
          e_lo = pick_exponent();
          word = word_with_exponents(e_lo, ($urandom_range(0, 2) == 0) ? e_lo
                                                                       : pick_exponent());
        end
        bin = ($urandom_range(0, 1) == 1) ? pick_exponent() : 8'($urandom_range(0, 255));
        drive_item(op, word, bin, 1'b0, ALL_ZERO);
      end
    end

    // drain, then watch a little longer for stray results
    wait_drained();
    steady_flow = 1'b1;
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // hang guard
  initial begin
    #LIMIT_NS;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: bf16_pair_exponent_split_histogram.f
hw/rtl/bpesh_pkg.sv
hw/rtl/bpesh_ram.sv
hw/rtl/bpesh_outq.sv
hw/rtl/bf16_pair_exponent_split_histogram.sv
sim/bf16_pair_exponent_split_histogram_test.sv
